[design/mwct_pkg.sv]
package mwct_pkg;

   localparam int MAX_JOBS = 64;
   localparam int MACHINES = 4;
   localparam int JOB_W = $clog2(MAX_JOBS);
   localparam int MACH_W = $clog2(MACHINES);
   localparam int CNT_W = JOB_W + 1;
   localparam int ADDR_W = MACH_W + JOB_W;
   localparam int DEPTH = MACHINES * MAX_JOBS;
   localparam int SUM_W = 22;
   localparam int COST_W = 46;
   localparam int VAL_W = 16;
   localparam int PROD_W = VAL_W + SUM_W;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_MOVE = 2'd2;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_ASSIGNED = 2'd1;
   localparam logic [1:0] STAT_UNASSIGNED = 2'd2;

   localparam logic CSR_JOBS_IN_USE = 1'b0;
   localparam logic [CNT_W-1:0] JOBS_RESET = CNT_W'(64);

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] job_index;
      logic [1:0] target_machine;
      logic [15:0] job_time;
      logic [15:0] job_weight;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [45:0] target_cost;
      logic [21:0] target_load;
      logic source_valid;
      logic [1:0] source_machine;
      logic [45:0] source_cost;
      logic [21:0] source_load;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DEL_WALK,
      ST_DEL_MUL,
      ST_DEL_ACC,
      ST_INS_WALK,
      ST_INS_MUL,
      ST_INS_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic check;
      logic walk;
      logic del;
      logic mul;
      logic acc;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_done;
      logic job_valid;
      logic [1:0] mode;
      logic rsp_free;
   } sts_type;

endpackage

[design/mwct_ctrl.sv]
module mwct_ctrl
   import mwct_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (sts.mode == MODE_INSERT) begin
               state_in = sts.job_valid ? ST_FINISH : ST_INS_WALK;
            end else if (sts.mode == MODE_DELETE) begin
               state_in = sts.job_valid ? ST_DEL_WALK : ST_FINISH;
            end else if (sts.mode == MODE_MOVE) begin
               state_in = sts.job_valid ? ST_DEL_WALK : ST_INS_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DEL_WALK: begin
            if (sts.walk_done) state_in = ST_DEL_MUL;
         end
         ST_DEL_MUL: state_in = ST_DEL_ACC;
         ST_DEL_ACC: begin
            state_in = (sts.mode == MODE_DELETE) ? ST_FINISH : ST_INS_WALK;
         end
         ST_INS_WALK: begin
            if (sts.walk_done) state_in = ST_INS_MUL;
         end
         ST_INS_MUL: state_in = ST_INS_ACC;
         ST_INS_ACC: state_in = ST_FINISH;
         ST_FINISH: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      cmd.accept = req_ready && req_valid;
      cmd.clear = (state_ff == ST_CLEAR);
      cmd.check = (state_ff == ST_CHECK);
      cmd.walk = (state_ff == ST_DEL_WALK) || (state_ff == ST_INS_WALK);
      cmd.del = (state_ff == ST_DEL_WALK) || (state_ff == ST_DEL_MUL) ||
                (state_ff == ST_DEL_ACC);
      cmd.mul = (state_ff == ST_DEL_MUL) || (state_ff == ST_INS_MUL);
      cmd.acc = (state_ff == ST_DEL_ACC) || (state_ff == ST_INS_ACC);
      cmd.load_rsp = (state_ff == ST_FINISH) && sts.rsp_free;
   end

endmodule

[design/mwct_datapath.sv]
module mwct_datapath
   import mwct_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   input  logic [CNT_W-1:0] jobs_in_use,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   req_type req_ff;
   logic [MAX_JOBS-1:0] job_valid_ff;
   logic [MACH_W-1:0] mach_mem [MAX_JOBS];
   logic [MACH_W-1:0] mach_rd_ff;

   logic [SUM_W-1:0] prefix_mem [DEPTH];
   logic [SUM_W-1:0] suffix_mem [DEPTH];
   logic [SUM_W-1:0] p_rd_ff, s_rd_ff;

   logic [ADDR_W:0] clr_ff;
   logic [CNT_W-1:0] widx_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic rd_v_ff;

   logic [SUM_W-1:0] p_cap_ff, s_cap_ff;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff;

   logic [COST_W-1:0] cost_ff [MACHINES];
   logic [SUM_W-1:0] load_ff [MACHINES];

   logic [1:0] status_ff;
   logic src_valid_ff;
   logic [MACH_W-1:0] smach_ff;
   logic [COST_W-1:0] tgt_cost_ff, src_cost_ff;
   logic [SUM_W-1:0] tgt_load_ff, src_load_ff;

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic [JOB_W-1:0] job;
   logic [MACH_W-1:0] tmach, msel;
   logic [CNT_W-1:0] lim, job_ext;
   logic issue, we, upd_p, upd_s;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [SUM_W-1:0] p_new, s_new, p_wr, s_wr, t_ext, w_ext;
   logic [COST_W-1:0] contrib, cost_new;
   logic [SUM_W-1:0] load_new;

   assign job = req_ff.job_index;
   assign tmach = req_ff.target_machine;
   assign msel = cmd.del ? smach_ff : tmach;
   assign lim = (jobs_in_use > CNT_W'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : jobs_in_use;
   assign job_ext = {1'b0, job};
   assign t_ext = SUM_W'(req_ff.job_time);
   assign w_ext = SUM_W'(req_ff.job_weight);

   assign issue = cmd.walk && (widx_ff != CNT_W'(MAX_JOBS));
   assign raddr = {msel, widx_ff[JOB_W-1:0]};

   // Writeback of the entry read in the previous cycle.
   assign upd_p = (rd_idx_ff >= job_ext) && (rd_idx_ff < lim);
   assign upd_s = (rd_idx_ff < job_ext);
   assign p_new = cmd.del ? p_rd_ff - t_ext : p_rd_ff + t_ext;
   assign s_new = cmd.del ? s_rd_ff - w_ext : s_rd_ff + w_ext;
   assign we = cmd.clear || rd_v_ff;
   assign waddr = cmd.clear ? clr_ff[ADDR_W-1:0] : {msel, rd_idx_ff[JOB_W-1:0]};
   assign p_wr = cmd.clear ? '0 : (upd_p ? p_new : p_rd_ff);
   assign s_wr = cmd.clear ? '0 : (upd_s ? s_new : s_rd_ff);

   assign contrib = COST_W'({1'b0, prod_a_ff} + {1'b0, prod_b_ff});
   assign cost_new = cmd.del ? cost_ff[msel] - contrib : cost_ff[msel] + contrib;
   assign load_new = cmd.del ? load_ff[msel] - t_ext : load_ff[msel] + t_ext;

   always_ff @(posedge clock) begin
      if (we) begin
         prefix_mem[waddr] <= p_wr;
         suffix_mem[waddr] <= s_wr;
      end
      p_rd_ff <= prefix_mem[raddr];
      s_rd_ff <= suffix_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) mach_rd_ff <= mach_mem[req_data.job_index];
      if (cmd.acc && !cmd.del) mach_mem[job] <= tmach;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         widx_ff <= '0;
         rd_v_ff <= 1'b0;
         job_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < MACHINES; m++) begin
            cost_ff[m] <= '0;
            load_ff[m] <= '0;
         end
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         widx_ff <= cmd.walk ? widx_ff + CNT_W'(issue) : '0;
         rd_v_ff <= issue;
         if (cmd.acc) begin
            cost_ff[msel] <= cost_new;
            load_ff[msel] <= load_new;
            job_valid_ff[job] <= !cmd.del;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= widx_ff;
      if (cmd.accept) req_ff <= req_data;
      if (rd_v_ff && (rd_idx_ff == job_ext)) begin
         // Delete uses the sums before the walk, insert the sums after it.
         p_cap_ff <= (cmd.del || !upd_p) ? p_rd_ff : p_new;
         s_cap_ff <= s_rd_ff;
      end
      if (cmd.mul) begin
         prod_a_ff <= PROD_W'(req_ff.job_weight) * PROD_W'(p_cap_ff);
         prod_b_ff <= PROD_W'(req_ff.job_time) * PROD_W'(s_cap_ff);
      end
      if (cmd.check) begin
         priority if (req_ff.mode == MODE_INSERT && job_valid_ff[job]) begin
            status_ff <= STAT_ASSIGNED;
         end else if (req_ff.mode == MODE_DELETE && !job_valid_ff[job]) begin
            status_ff <= STAT_UNASSIGNED;
         end else begin
            status_ff <= STAT_OK;
         end
         src_valid_ff <= job_valid_ff[job] &&
                         (req_ff.mode == MODE_DELETE || req_ff.mode == MODE_MOVE);
         smach_ff <= mach_rd_ff;
         tgt_cost_ff <= '0;
         tgt_load_ff <= '0;
         src_cost_ff <= '0;
         src_load_ff <= '0;
      end
      if (cmd.acc) begin
         if (cmd.del) begin
            src_cost_ff <= cost_new;
            src_load_ff <= load_new;
         end else begin
            tgt_cost_ff <= cost_new;
            tgt_load_ff <= load_new;
            if (src_valid_ff && smach_ff == tmach) begin
               src_cost_ff <= cost_new;
               src_load_ff <= load_new;
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff.status <= status_ff;
         rsp_ff.target_cost <= tgt_cost_ff;
         rsp_ff.target_load <= tgt_load_ff;
         rsp_ff.source_valid <= src_valid_ff;
         rsp_ff.source_machine <= src_valid_ff ? smach_ff : '0;
         rsp_ff.source_cost <= src_cost_ff;
         rsp_ff.source_load <= src_load_ff;
      end
   end

   always_comb begin
      sts.clear_done = (clr_ff == (ADDR_W+1)'(DEPTH));
      sts.walk_done = cmd.walk && !issue && !rd_v_ff;
      sts.job_valid = job_valid_ff[job];
      sts.mode = req_ff.mode;
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

[design/machine_weighted_completion_tracker_unit.sv]
// Each request walks the sum memories of one machine, a move of an assigned job
// two (the source, then the target); an error or unused mode walks none. In a walk
// the 64 entries of that machine are read one a cycle and each is written back in
// the following cycle.
// One request is handled at a time; the next is taken while a result waits.
// Reset: synchronous; afterwards a clearing pass zeroes the sum memories.
module machine_weighted_completion_tracker_unit
   import mwct_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [2:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   cmd_type cmd;
   sts_type sts;
   logic [CNT_W-1:0] jobs_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         jobs_ff <= JOBS_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_JOBS_IN_USE) begin
         jobs_ff <= pwdata[CNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_JOBS_IN_USE) ? 32'(jobs_ff) : '0;

   mwct_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts(sts),
      .cmd(cmd)
   );

   mwct_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_data(req_data),
      .jobs_in_use(jobs_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

[dv/machine_weighted_completion_tracker_unit_test.sv]
module machine_weighted_completion_tracker_unit_test;
   import mwct_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [2:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   machine_weighted_completion_tracker_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the tracker state used to predict each response.
   logic [21:0] prefix_sum [MACHINES][MAX_JOBS];
   logic [21:0] suffix_sum [MACHINES][MAX_JOBS];
   logic [45:0] mach_cost [MACHINES];
   logic [21:0] mach_load [MACHINES];
   bit job_on [MAX_JOBS];
   logic [1:0] job_mach [MAX_JOBS];
   logic [6:0] jobs_limit;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int unsigned issued_cnt, accepted_cnt, rsp_cnt;
   int unsigned errors;
   int unsigned req_gap, rsp_gap;
   bit no_idle;

   // Generator view of which jobs are on a machine, and with what values.
   bit gen_on [MAX_JOBS];
   logic [15:0] gen_time [MAX_JOBS];
   logic [15:0] gen_weight [MAX_JOBS];

   function automatic int unsigned walk_end();
      return (jobs_limit > MAX_JOBS) ? MAX_JOBS : jobs_limit;
   endfunction

   function automatic logic [45:0] job_share(int m, int j, logic [15:0] t, logic [15:0] w);
      logic [63:0] acc;
      acc = 64'(w) * 64'(prefix_sum[m][j]) + 64'(t) * 64'(suffix_sum[m][j]);
      return acc[45:0];
   endfunction

   task automatic add_job(int m, int j, logic [15:0] t, logic [15:0] w);
      job_on[j] = 1;
      job_mach[j] = 2'(m);
      for (int i = j; i < walk_end(); i++) prefix_sum[m][i] = prefix_sum[m][i] + t;
      for (int i = 0; i < j; i++) suffix_sum[m][i] = suffix_sum[m][i] + w;
      mach_cost[m] = mach_cost[m] + job_share(m, j, t, w);
      mach_load[m] = mach_load[m] + t;
   endtask

   task automatic drop_job(int j, logic [15:0] t, logic [15:0] w, output int m);
      m = job_mach[j];
      job_on[j] = 0;
      mach_cost[m] = mach_cost[m] - job_share(m, j, t, w);
      mach_load[m] = mach_load[m] - t;
      for (int i = j; i < walk_end(); i++) prefix_sum[m][i] = prefix_sum[m][i] - t;
      for (int i = 0; i < j; i++) suffix_sum[m][i] = suffix_sum[m][i] - w;
   endtask

   task automatic predict_tracker(req_type r, output rsp_type o);
      int j, tm, sm;
      j = r.job_index;
      tm = r.target_machine;
      o = '0;
      if (r.mode == MODE_INSERT || r.mode == MODE_MOVE) begin
         if (job_on[j] && r.mode == MODE_INSERT) begin
            o.status = STAT_ASSIGNED;
         end else begin
            if (job_on[j]) begin
               drop_job(j, r.job_time, r.job_weight, sm);
               o.source_valid = 1;
               o.source_machine = 2'(sm);
            end
            add_job(tm, j, r.job_time, r.job_weight);
            o.target_cost = mach_cost[tm];
            o.target_load = mach_load[tm];
            // The source totals are read after the insert, so a move onto the
            // same machine reports the combined result.
            if (o.source_valid) begin
               o.source_cost = mach_cost[o.source_machine];
               o.source_load = mach_load[o.source_machine];
            end
         end
      end else if (r.mode == MODE_DELETE) begin
         if (!job_on[j]) begin
            o.status = STAT_UNASSIGNED;
         end else begin
            drop_job(j, r.job_time, r.job_weight, sm);
            o.source_valid = 1;
            o.source_machine = 2'(sm);
            o.source_cost = mach_cost[sm];
            o.source_load = mach_load[sm];
         end
      end
   endtask

   function automatic int unsigned pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Request driver.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         req_valid <= 0;
         req_data <= '0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_tracker(req_data, exp_rsp);
            expected_rsps.push_back(exp_rsp);
            accepted_cnt++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1;
               req_data <= pending_reqs.pop_front();
               issued_cnt++;
               req_gap <= pick_gap();
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_cnt++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.target_cost !== e.target_cost) begin
                  $error("target_cost: expected %0d actual %0d", e.target_cost,
                         rsp_data.target_cost);
                  errors++;
               end
               if (rsp_data.target_load !== e.target_load) begin
                  $error("target_load: expected %0d actual %0d", e.target_load,
                         rsp_data.target_load);
                  errors++;
               end
               if (rsp_data.source_valid !== e.source_valid) begin
                  $error("source_valid: expected %0d actual %0d", e.source_valid,
                         rsp_data.source_valid);
                  errors++;
               end
               if (rsp_data.source_machine !== e.source_machine) begin
                  $error("source_machine: expected %0d actual %0d", e.source_machine,
                         rsp_data.source_machine);
                  errors++;
               end
               if (rsp_data.source_cost !== e.source_cost) begin
                  $error("source_cost: expected %0d actual %0d", e.source_cost,
                         rsp_data.source_cost);
                  errors++;
               end
               if (rsp_data.source_load !== e.source_load) begin
                  $error("source_load: expected %0d actual %0d", e.source_load,
                         rsp_data.source_load);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            rsp_gap <= pick_gap();
         end
      end
   end

   function automatic req_type make_req(logic [1:0] md, int j, int m, int t, int w);
      req_type r;
      r.mode = md;
      r.job_index = 6'(j);
      r.target_machine = 2'(m);
      r.job_time = 16'(t);
      r.job_weight = 16'(w);
      return r;
   endfunction

   task automatic push_req(req_type r);
      int j;
      j = r.job_index;
      if (r.mode == MODE_INSERT && !gen_on[j] || r.mode == MODE_MOVE) begin
         gen_on[j] = 1;
         gen_time[j] = r.job_time;
         gen_weight[j] = r.job_weight;
      end else if (r.mode == MODE_DELETE) begin
         gen_on[j] = 0;
      end
      pending_reqs.push_back(r);
   endtask

   task automatic push_random_req();
      int j, sel;
      req_type r;
      j = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
      sel = $urandom_range(0, 99);
      r = make_req(MODE_INSERT, j, $urandom_range(0, 3),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500),
                   ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500));
      if (sel < 60) begin
         if (gen_on[j]) begin
            r.mode = MODE_DELETE;
            r.job_time = gen_time[j];
            r.job_weight = gen_weight[j];
         end
      end else if (sel < 80) begin
         r.mode = MODE_MOVE;
      end else begin
         r.mode = 2'($urandom_range(0, 3));
         r.job_time = 16'($urandom);
         r.job_weight = 16'($urandom);
      end
      push_req(r);
   endtask

   task automatic wait_drained(int unsigned extra);
      do @(posedge clock);
      while (!(pending_reqs.size() == 0 && issued_cnt == accepted_cnt &&
               expected_rsps.size() == 0));
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_jobs_limit(logic [6:0] v);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= 3'd0; pwdata <= {25'($urandom), v};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      jobs_limit = v;
      // Read it back.
      @(posedge clock);
      psel <= 1;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata[6:0] !== v) begin
         $error("jobs_in_use: expected %0d actual %0d", v, prdata[6:0]);
         errors++;
      end
      psel <= 0; penable <= 0;
      @(posedge clock);
   endtask

   initial begin
      logic [6:0] limits [7];
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      errors = 0; issued_cnt = 0; accepted_cnt = 0; rsp_cnt = 0;
      no_idle = 0;
      for (int m = 0; m < MACHINES; m++) begin
         mach_cost[m] = '0;
         mach_load[m] = '0;
         for (int i = 0; i < MAX_JOBS; i++) begin
            prefix_sum[m][i] = '0;
            suffix_sum[m][i] = '0;
         end
      end
      for (int i = 0; i < MAX_JOBS; i++) begin
         job_on[i] = 0; job_mach[i] = 0; gen_on[i] = 0;
      end
      jobs_limit = 7'd64;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed requests.
      push_req(make_req(MODE_INSERT, 0, 0, 16'hFFFF, 16'hFFFF));
      push_req(make_req(MODE_INSERT, 63, 3, 16'hFFFF, 16'hFFFF));
      push_req(make_req(MODE_INSERT, 10, 0, 100, 7));
      push_req(make_req(MODE_INSERT, 20, 0, 0, 0));
      push_req(make_req(MODE_INSERT, 10, 1, 5, 5));
      push_req(make_req(MODE_DELETE, 30, 2, 5, 5));
      push_req(make_req(MODE_MOVE, 10, 2, 100, 7));
      push_req(make_req(MODE_MOVE, 10, 2, 33, 44));
      push_req(make_req(MODE_MOVE, 40, 1, 12, 34));
      push_req(make_req(2'd3, 41, 3, 16'hFFFF, 16'hFFFF));
      push_req(make_req(MODE_DELETE, 20, 0, 0, 0));
      push_req(make_req(MODE_DELETE, 0, 0, 1, 2));
      push_req(make_req(MODE_DELETE, 63, 0, 16'hFFFF, 16'hFFFF));
      push_req(make_req(MODE_INSERT, 5, 3, 16'hAAAA, 16'h5555));
      push_req(make_req(MODE_INSERT, 6, 3, 16'h5555, 16'hAAAA));
      push_req(make_req(MODE_DELETE, 40, 3, 12, 34));
      wait_drained(0);

      limits = '{7'd1, 7'd0, 7'd127, 7'd64, 7'($urandom_range(2, 63)), 7'd32, 7'd64};
      for (int p = 0; p < 7; p++) begin
         // Wait out any walk still running before touching the register.
         repeat (160) @(posedge clock);
         write_jobs_limit(limits[p]);
         no_idle = (p == 3);
         if (p == 0) begin
            push_req(make_req(MODE_INSERT, 3, 1, 9, 9));
            push_req(make_req(MODE_INSERT, 0, 1, 4, 4));
         end
         for (int k = 0; k < 85; k++) push_random_req();
         wait_drained(0);
      end
      wait_drained(200);
      $display("Ran %0d requests and %0d responses across 8 jobs_in_use settings,",
               accepted_cnt, rsp_cnt);
      $display("covering insert, delete, move, unused mode and error statuses.");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
